[rtl/path_expression_tokenizer_unit_assert.svh]
// Assertion macros for the checker of the path expression tokenizer.
// Stands alone; the including file supplies clock, reset and the expressions.
`ifndef PATH_EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH
`define PATH_EXPRESSION_TOKENIZER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge.
`define PET_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("path tokenizer check failed");

// Next-cycle implication, checked at every rising clock edge.
`define PET_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("path tokenizer check failed");

`endif

[rtl/pet_pkg.sv]
// Package of the path expression tokenizer: constants, codes, item types and
// the character classifier. Depends on nothing; all the modules use it.
`default_nettype none

package pet_pkg;

   // Defaults of the top-level parameters.
   localparam int STACK_DEPTH_DEF = 8;
   localparam int INDEX_BITS_DEF  = 32;

   // Field widths.
   localparam int MODE_W    = 4;
   localparam int EVENT_W   = 4;
   localparam int CHAR_W    = 8;
   localparam int OUT_IDX_W = 32;

   // Queue depths and the bound on mode steps for one character.
   localparam int REQ_QUEUE_DEPTH = 2;
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int STEP_GUARD      = 16;

   // Result event codes.
   localparam logic [EVENT_W-1:0] EV_LEVEL      = 4'd0;
   localparam logic [EVENT_W-1:0] EV_RECURSIVE  = 4'd1;
   localparam logic [EVENT_W-1:0] EV_KEY_CHAR   = 4'd2;
   localparam logic [EVENT_W-1:0] EV_KEY_END    = 4'd3;
   localparam logic [EVENT_W-1:0] EV_PRED_BEGIN = 4'd4;
   localparam logic [EVENT_W-1:0] EV_PRED_END   = 4'd5;
   localparam logic [EVENT_W-1:0] EV_RANGE      = 4'd6;
   localparam logic [EVENT_W-1:0] EV_MASK_CHAR  = 4'd7;
   localparam logic [EVENT_W-1:0] EV_MASK_END   = 4'd8;
   localparam logic [EVENT_W-1:0] EV_BAD_PRED   = 4'd9;
   localparam logic [EVENT_W-1:0] EV_NOT_PATH   = 4'd10;

   // Parse mode codes held on the mode stack.
   localparam logic [MODE_W-1:0] M_BEGIN    = 4'd0;
   localparam logic [MODE_W-1:0] M_TOKEN    = 4'd1;
   localparam logic [MODE_W-1:0] M_RECURSE  = 4'd2;
   localparam logic [MODE_W-1:0] M_KEY      = 4'd3;
   localparam logic [MODE_W-1:0] M_PRED     = 4'd4;
   localparam logic [MODE_W-1:0] M_IFROM    = 4'd5;
   localparam logic [MODE_W-1:0] M_ITO      = 4'd6;
   localparam logic [MODE_W-1:0] M_ENDRANGE = 4'd7;
   localparam logic [MODE_W-1:0] M_RSEP     = 4'd8;
   localparam logic [MODE_W-1:0] M_MASK     = 4'd9;
   localparam logic [MODE_W-1:0] M_SPACES   = 4'd10;

   // Characters with a meaning in a path.
   localparam logic [CHAR_W-1:0] CH_END      = 8'h00;
   localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
   localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
   localparam logic [CHAR_W-1:0] CH_RBRACKET = 8'h5D;
   localparam logic [CHAR_W-1:0] CH_TILDE    = 8'h7E;
   localparam logic [CHAR_W-1:0] CH_DASH     = 8'h2D;
   localparam logic [CHAR_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [CHAR_W-1:0] CH_TAB      = 8'h09;
   localparam logic [CHAR_W-1:0] CH_CR       = 8'h0D;
   localparam logic [CHAR_W-1:0] CH_ZERO     = 8'h30;
   localparam logic [CHAR_W-1:0] CH_NINE     = 8'h39;

   // One input character together with its classification.
   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              is_end;
      logic              is_slash;
      logic              is_lbr;
      logic              is_rbr;
      logic              is_tilde;
      logic              is_dash;
      logic              is_digit;
      logic              is_space;
      logic [3:0]        digit;
   } char_info_type;

   // One result item.
   typedef struct packed {
      logic [EVENT_W-1:0]   event_res;
      logic [CHAR_W-1:0]    char_value;
      logic [OUT_IDX_W-1:0] index_from;
      logic [OUT_IDX_W-1:0] index_to;
      logic                 open_end;
      logic                 last;
   } result_type;

   // Classify one character as it enters the block.
   function automatic char_info_type classify(input logic [CHAR_W-1:0] ch);
      char_info_type info;
      logic [CHAR_W-1:0] offset;
      offset        = ch - CH_ZERO;
      info.ch       = ch;
      info.is_end   = (ch == CH_END);
      info.is_slash = (ch == CH_SLASH);
      info.is_lbr   = (ch == CH_LBRACKET);
      info.is_rbr   = (ch == CH_RBRACKET);
      info.is_tilde = (ch == CH_TILDE);
      info.is_dash  = (ch == CH_DASH);
      info.is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
      info.is_space = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
      info.digit    = offset[3:0];
      return info;
   endfunction

endpackage

`default_nettype wire

[rtl/pet_front.sv]
// Front end of the path expression tokenizer: accepts characters, classifies
// them and holds them in a short queue for the parser. Uses pet_pkg.
`default_nettype none

module pet_front (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire logic [7:0]              req_ch,
   output logic                         full,
   output logic                         head_valid,
   output pet_pkg::char_info_type       head,
   input  wire logic                    deq
);

   localparam int DEPTH = pet_pkg::REQ_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

   pet_pkg::char_info_type entry_ff [DEPTH];
   pet_pkg::char_info_type entry_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept;

   // Handshake and head of the queue.
   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign entry_in   = pet_pkg::classify(req_ch);

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (deq) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({accept, deq})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= entry_in;
      end
   end

endmodule

`default_nettype wire

[rtl/pet_rsp_queue.sv]
// Result queue of the path expression tokenizer: holds finished result items
// until they are taken at the result port. Uses pet_pkg.
`default_nettype none

module pet_rsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire pet_pkg::result_type  wr_data,
   output logic                      full,
   output logic                      empty,
   input  wire logic                 pop,
   output pet_pkg::result_type       rd_data
);

   localparam int DEPTH = pet_pkg::RSP_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   pet_pkg::result_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             take;

   // Status and the oldest item.
   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign rd_data = entry_ff[rd_ptr_ff];
   assign take    = pop && !empty;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (take) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({wr_en, take})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

[rtl/pet_back.sv]
// Parser of the path expression tokenizer: one mode-stack step per cycle on the
// head character, save while a result waits or is flushed; emits items. Uses pet_pkg.
`default_nettype none

module pet_back #(
   parameter int STACK_DEPTH = pet_pkg::STACK_DEPTH_DEF,
   parameter int INDEX_BITS  = pet_pkg::INDEX_BITS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    in_valid,
   input  wire pet_pkg::char_info_type  in_item,
   output logic                         in_deq,
   input  wire logic                    out_full,
   output logic                         out_wr,
   output pet_pkg::result_type          out_data
);

   localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
   localparam int TOP_W   = $clog2(STACK_DEPTH);
   localparam int ACC_W   = INDEX_BITS + 4;
   localparam int GUARD_W = $clog2(pet_pkg::STEP_GUARD);
   localparam int MODE_W  = pet_pkg::MODE_W;
   localparam int OUT_W   = pet_pkg::OUT_IDX_W;
   localparam logic [CNT_W-1:0]      CNT_DEPTH  = CNT_W'(STACK_DEPTH);
   localparam logic [CNT_W-1:0]      CNT_RESET  = CNT_W'(2);
   localparam logic [INDEX_BITS-1:0] IDX_MAX    = '1;
   localparam logic [GUARD_W-1:0]    GUARD_LAST = GUARD_W'(pet_pkg::STEP_GUARD - 1);

   // Sequencer states.
   localparam logic ST_STEP  = 1'b0;
   localparam logic ST_FLUSH = 1'b1;

   logic                      state_ff, state_in;
   logic [MODE_W-1:0]         mode_ff [STACK_DEPTH];
   logic [MODE_W-1:0]         mode_in [STACK_DEPTH];
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [INDEX_BITS-1:0]     start_ff, start_in;
   logic [INDEX_BITS-1:0]     end_ff, end_in;
   logic                      unset_ff, unset_in;
   logic                      halted_ff, halted_in;
   logic                      pend_valid_ff, pend_valid_in;
   pet_pkg::result_type       pend_ff, pend_in;
   logic [GUARD_W-1:0]        guard_ff, guard_in;

   // Outcome of one mode step.
   logic                      s_emit;
   pet_pkg::result_type       s_res;
   logic                      s_pop;
   logic [2:0]                s_npush;
   logic [MODE_W-1:0]         s_push [8];
   logic                      s_consumed;
   logic                      s_stop;
   logic                      s_halt;
   logic                      s_range_clear;
   logic                      s_acc_from;
   logic                      s_acc_to;
   logic                      s_set_unset;

   logic [CNT_W-1:0]          cnt_m1;
   logic [TOP_W-1:0]          top_idx;
   logic [MODE_W-1:0]         top_mode;
   logic [INDEX_BITS-1:0]     acc_src;
   logic [INDEX_BITS-1:0]     acc_val;
   logic                      range_open;

   // Low result bits of an index value, zero-extended where it is narrower.
   function automatic logic [OUT_W-1:0] low_out(input logic [INDEX_BITS-1:0] v);
      logic [INDEX_BITS+OUT_W-1:0] wide;
      wide = {{OUT_W{1'b0}}, v};
      return wide[OUT_W-1:0];
   endfunction

   // Top of the mode stack.
   assign cnt_m1   = count_ff - 1'b1;
   assign top_idx  = cnt_m1[TOP_W-1:0];
   assign top_mode = mode_ff[top_idx];

   // Shared decimal accumulator: value times ten plus digit, saturating.
   always_comb begin
      logic [ACC_W-1:0] prod;
      acc_src = (top_mode == pet_pkg::M_ITO) ? (unset_ff ? '0 : end_ff) : start_ff;
      prod    = ({4'b0000, acc_src} << 3) + ({4'b0000, acc_src} << 1)
                + ACC_W'(in_item.digit);
      acc_val = (prod > {4'b0000, IDX_MAX}) ? IDX_MAX : prod[INDEX_BITS-1:0];
   end

   assign range_open = unset_ff || (end_ff < start_ff);

   // Decode one mode step for the head character.
   always_comb begin
      s_emit         = 1'b0;
      s_res          = '0;
      s_pop          = 1'b0;
      s_npush        = 3'd0;
      for (int k = 0; k < 8; k++) begin
         s_push[k] = pet_pkg::M_BEGIN;
      end
      s_consumed     = 1'b1;
      s_stop         = 1'b0;
      s_halt         = 1'b0;
      s_range_clear  = 1'b0;
      s_acc_from     = 1'b0;
      s_acc_to       = 1'b0;
      s_set_unset    = 1'b0;
      unique case (top_mode)
         pet_pkg::M_BEGIN: begin
            if (in_item.is_slash) begin
               s_pop      = 1'b1;
               s_npush    = 3'd1;
               s_push[0]  = pet_pkg::M_TOKEN;
               s_consumed = 1'b0;
            end else begin
               s_emit          = 1'b1;
               s_res.event_res = pet_pkg::EV_NOT_PATH;
               s_halt          = 1'b1;
               s_stop          = 1'b1;
            end
         end
         pet_pkg::M_TOKEN: begin
            if (in_item.is_end) begin
               s_consumed = 1'b1;
            end else if (in_item.is_slash) begin
               s_npush   = 3'd1;
               s_push[0] = pet_pkg::M_RECURSE;
            end else if (in_item.is_lbr) begin
               s_emit          = 1'b1;
               s_res.event_res = pet_pkg::EV_PRED_BEGIN;
               s_npush         = 3'd2;
               s_push[0]       = pet_pkg::M_PRED;
               s_push[1]       = pet_pkg::M_SPACES;
            end else begin
               s_npush    = 3'd1;
               s_push[0]  = pet_pkg::M_KEY;
               s_consumed = 1'b0;
            end
         end
         pet_pkg::M_RECURSE: begin
            s_pop  = 1'b1;
            s_emit = 1'b1;
            if (in_item.is_slash) begin
               s_res.event_res = pet_pkg::EV_RECURSIVE;
            end else begin
               s_res.event_res = pet_pkg::EV_LEVEL;
               s_consumed      = 1'b0;
            end
         end
         pet_pkg::M_KEY: begin
            s_emit = 1'b1;
            if (in_item.is_end || in_item.is_slash || in_item.is_lbr) begin
               s_res.event_res = pet_pkg::EV_KEY_END;
               s_pop           = 1'b1;
               s_consumed      = 1'b0;
            end else begin
               s_res.event_res  = pet_pkg::EV_KEY_CHAR;
               s_res.char_value = in_item.ch;
            end
         end
         pet_pkg::M_PRED: begin
            if (in_item.is_rbr) begin
               s_emit          = 1'b1;
               s_res.event_res = pet_pkg::EV_PRED_END;
               s_pop           = 1'b1;
            end else if (in_item.is_digit) begin
               s_npush       = 3'd5;
               s_push[0]     = pet_pkg::M_ENDRANGE;
               s_push[1]     = pet_pkg::M_SPACES;
               s_push[2]     = pet_pkg::M_RSEP;
               s_push[3]     = pet_pkg::M_SPACES;
               s_push[4]     = pet_pkg::M_IFROM;
               s_range_clear = 1'b1;
               s_consumed    = 1'b0;
            end else if (in_item.is_tilde) begin
               s_npush   = 3'd1;
               s_push[0] = pet_pkg::M_MASK;
            end else begin
               s_emit          = 1'b1;
               s_res.event_res = pet_pkg::EV_BAD_PRED;
               s_halt          = 1'b1;
               s_stop          = 1'b1;
            end
         end
         pet_pkg::M_IFROM: begin
            if (in_item.is_digit) begin
               s_acc_from = 1'b1;
            end else begin
               s_pop      = 1'b1;
               s_consumed = 1'b0;
            end
         end
         pet_pkg::M_ITO: begin
            if (in_item.is_digit) begin
               s_acc_to = 1'b1;
            end else begin
               s_pop      = 1'b1;
               s_consumed = 1'b0;
            end
         end
         pet_pkg::M_RSEP: begin
            s_pop = 1'b1;
            if (in_item.is_dash) begin
               s_npush     = 3'd1;
               s_push[0]   = pet_pkg::M_ITO;
               s_set_unset = 1'b1;
            end else begin
               s_consumed = 1'b0;
            end
         end
         pet_pkg::M_ENDRANGE: begin
            s_emit           = 1'b1;
            s_res.event_res  = pet_pkg::EV_RANGE;
            s_res.index_from = low_out(start_ff);
            s_res.index_to   = range_open ? low_out(IDX_MAX) : low_out(end_ff);
            s_res.open_end   = range_open;
            s_pop            = 1'b1;
            s_consumed       = 1'b0;
         end
         pet_pkg::M_MASK: begin
            if (in_item.is_rbr) begin
               s_emit          = 1'b1;
               s_res.event_res = pet_pkg::EV_MASK_END;
               s_pop           = 1'b1;
               s_consumed      = 1'b0;
            end else if (!in_item.is_end) begin
               s_emit           = 1'b1;
               s_res.event_res  = pet_pkg::EV_MASK_CHAR;
               s_res.char_value = in_item.ch;
            end
         end
         pet_pkg::M_SPACES: begin
            if (!in_item.is_space) begin
               s_pop      = 1'b1;
               s_consumed = 1'b0;
            end
         end
         default: begin
            s_pop      = 1'b1;
            s_consumed = 1'b0;
         end
      endcase
   end

   // Sequencer: apply a step, hold back the newest result, flush it at the end.
   always_comb begin
      logic [CNT_W-1:0] base;
      logic [CNT_W:0]   sum;
      logic [CNT_W-1:0] diff;
      logic             done;
      logic             path_end;
      state_in      = state_ff;
      mode_in       = mode_ff;
      count_in      = count_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      unset_in      = unset_ff;
      halted_in     = halted_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      guard_in      = guard_ff;
      in_deq        = 1'b0;
      out_wr        = 1'b0;
      out_data      = pend_ff;
      out_data.last = 1'b0;
      done          = 1'b0;
      path_end      = 1'b0;
      base          = count_ff - CNT_W'(s_pop);
      sum           = {1'b0, base} + (CNT_W + 1)'(s_npush);
      diff          = '0;
      unique case (state_ff)
         ST_STEP: begin
            if (in_valid) begin
               if (halted_ff) begin
                  // Halted: characters are dropped until the end of the path.
                  in_deq   = 1'b1;
                  path_end = in_item.is_end;
               end else if (count_ff == '0) begin
                  done = 1'b1;
               end else if (!(s_emit && pend_valid_ff && out_full)) begin
                  if (s_emit) begin
                     if (pend_valid_ff) begin
                        out_wr = 1'b1;
                     end
                     pend_in       = s_res;
                     pend_valid_in = 1'b1;
                  end
                  // Pop then push onto the mode stack; pushes past the top are lost.
                  for (int i = 0; i < STACK_DEPTH; i++) begin
                     diff = CNT_W'(i) - base;
                     if ((CNT_W'(i) >= base) && (diff < CNT_W'(s_npush))) begin
                        mode_in[i] = s_push[diff[2:0]];
                     end
                  end
                  count_in = (sum > {1'b0, CNT_DEPTH}) ? CNT_DEPTH : sum[CNT_W-1:0];
                  // Range registers.
                  if (s_range_clear) begin
                     start_in = '0;
                     end_in   = '0;
                     unset_in = 1'b0;
                  end
                  if (s_acc_from) begin
                     start_in = acc_val;
                     end_in   = acc_val;
                  end
                  if (s_acc_to) begin
                     end_in   = acc_val;
                     unset_in = 1'b0;
                  end
                  if (s_set_unset) begin
                     unset_in = 1'b1;
                  end
                  if (s_halt) begin
                     halted_in = 1'b1;
                  end
                  done = s_stop || in_item.is_end || s_consumed || (guard_ff == GUARD_LAST);
                  if (!done) begin
                     guard_in = guard_ff + 1'b1;
                  end
               end
               if (done) begin
                  in_deq   = 1'b1;
                  guard_in = '0;
                  path_end = in_item.is_end;
                  if (pend_valid_in) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!out_full) begin
               out_wr        = 1'b1;
               out_data.last = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_STEP;
            end
         end
         default: begin
            state_in = ST_STEP;
         end
      endcase
      // End of path: back to the parse state after reset, ready for a new path.
      if (path_end) begin
         mode_in[0] = pet_pkg::M_BEGIN;
         mode_in[1] = pet_pkg::M_SPACES;
         count_in   = CNT_RESET;
         start_in   = '0;
         end_in     = '0;
         unset_in   = 1'b0;
         halted_in  = 1'b0;
      end
   end

   // Control and parse state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_STEP;
         for (int i = 0; i < STACK_DEPTH; i++) begin
            mode_ff[i] <= pet_pkg::M_BEGIN;
         end
         mode_ff[1]    <= pet_pkg::M_SPACES;
         count_ff      <= CNT_RESET;
         start_ff      <= '0;
         end_ff        <= '0;
         unset_ff      <= 1'b0;
         halted_ff     <= 1'b0;
         pend_valid_ff <= 1'b0;
         guard_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         count_ff      <= count_in;
         start_ff      <= start_in;
         end_ff        <= end_in;
         unset_ff      <= unset_in;
         halted_ff     <= halted_in;
         pend_valid_ff <= pend_valid_in;
         guard_ff      <= guard_in;
      end
   end

   // Held result item.
   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

`default_nettype wire

[rtl/path_expression_tokenizer_unit.sv]
// Top level of the path expression tokenizer: front queue, mode-stack parser
// and result queue. Uses pet_pkg, pet_front, pet_back and pet_rsp_queue.
//
//   Channel   Handshake           Payload
//   request   push / full         req_ch (8 bit, 0 ends the path)
//   result    empty / pop         rsp_event_res, rsp_char_value, rsp_index_from,
//                                 rsp_index_to, rsp_open_end, rsp_last
//
// A character passes through one or more mode steps in the parser, at most 16,
// and its final result is handed over in the flush state when it gives any.
// After a halt, characters up to the end of the path are dropped unparsed.
// Synchronous reset empties both queues and restores the parse state at once.
// The front queue holds two characters and the result queue four items; the
// parser waits only when it has a result to store and the result queue is full.
`default_nettype none

module path_expression_tokenizer_unit #(
   parameter int STACK_DEPTH = pet_pkg::STACK_DEPTH_DEF,
   parameter int INDEX_BITS  = pet_pkg::INDEX_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_ch,
   output logic             empty,
   input  wire logic        pop,
   output logic [3:0]       rsp_event_res,
   output logic [7:0]       rsp_char_value,
   output logic [31:0]      rsp_index_from,
   output logic [31:0]      rsp_index_to,
   output logic             rsp_open_end,
   output logic             rsp_last
);

   pet_pkg::char_info_type head;
   logic                   head_valid;
   logic                   deq;
   logic                   rq_full;
   logic                   rq_wr;
   pet_pkg::result_type    rq_wr_data;
   pet_pkg::result_type    rq_rd_data;

   // Character intake and classification.
   pet_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .req_ch     (req_ch),
      .full       (full),
      .head_valid (head_valid),
      .head       (head),
      .deq        (deq)
   );

   // Mode-stack parser.
   pet_back #(
      .STACK_DEPTH (STACK_DEPTH),
      .INDEX_BITS  (INDEX_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_valid (head_valid),
      .in_item  (head),
      .in_deq   (deq),
      .out_full (rq_full),
      .out_wr   (rq_wr),
      .out_data (rq_wr_data)
   );

   // Result queue towards the consumer.
   pet_rsp_queue u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rq_wr),
      .wr_data (rq_wr_data),
      .full    (rq_full),
      .empty   (empty),
      .pop     (pop),
      .rd_data (rq_rd_data)
   );

   // Result fields.
   assign rsp_event_res  = rq_rd_data.event_res;
   assign rsp_char_value = rq_rd_data.char_value;
   assign rsp_index_from = rq_rd_data.index_from;
   assign rsp_index_to   = rq_rd_data.index_to;
   assign rsp_open_end   = rq_rd_data.open_end;
   assign rsp_last       = rq_rd_data.last;

endmodule

`default_nettype wire

[rtl/pet_checker.sv]
// Port checker of the path expression tokenizer, bound to the top level.
// Uses pet_pkg and the macros of path_expression_tokenizer_unit_assert.svh.
`default_nettype none

`include "path_expression_tokenizer_unit_assert.svh"

module pet_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        empty,
   input  wire logic        pop,
   input  wire logic [3:0]  rsp_event_res,
   input  wire logic [7:0]  rsp_char_value,
   input  wire logic [31:0] rsp_index_from,
   input  wire logic [31:0] rsp_index_to,
   input  wire logic        rsp_open_end,
   input  wire logic        rsp_last
);

   logic       char_event;
   logic       range_event;
   logic       range_zero;
   logic [4:0] held_tag;

   // Classes and parts of the waiting result item.
   assign char_event  = (rsp_event_res == pet_pkg::EV_KEY_CHAR) ||
                        (rsp_event_res == pet_pkg::EV_MASK_CHAR);
   assign range_event = (rsp_event_res == pet_pkg::EV_RANGE);
   assign range_zero  = (rsp_index_from == 32'd0) && (rsp_index_to == 32'd0) &&
                        !rsp_open_end;
   assign held_tag    = {rsp_event_res, rsp_last};

   // Reset leaves no result item waiting.
   `PET_ASSERT_NXT(a_reset_empty, clock, 1'b0, reset, empty)

   // Only defined event codes reach the result port.
   `PET_ASSERT_IMP(a_event_known, clock, reset, !empty, rsp_event_res <= pet_pkg::EV_NOT_PATH)

   // A character value comes only with key and mask characters.
   `PET_ASSERT_IMP(a_char_only_chars, clock, reset, !empty && !char_event, rsp_char_value == 8'd0)

   // Range fields are zero on every item that is not a range.
   `PET_ASSERT_IMP(a_range_only_ranges, clock, reset, !empty && !range_event, range_zero)

   // A waiting result item keeps its event code and last flag until it is taken.
   `PET_ASSERT_NXT(a_result_holds, clock, reset, !empty && !pop, !empty && $stable(held_tag))

endmodule

bind path_expression_tokenizer_unit pet_checker u_pet_checker (.*);

`default_nettype wire
